// ===== design/dtd_pkg.sv =====
// shared types and constants for the difficulty to target divider
// no dependencies; imported by every module of the block
`default_nettype none

package dtd_pkg;

    localparam int unsigned DIFF_W   = 64;
    localparam int unsigned QUOT_W   = 256;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned NUM_WORDS = QUOT_W / WORD_W;
    localparam int unsigned CNT_W    = $clog2(QUOT_W);
    localparam int unsigned IDX_W    = $clog2(NUM_WORDS);

    // difficulty-one numerator is 0xffff << 208
    localparam logic [CNT_W-1:0] NUMER_LOW_BIT  = CNT_W'(208);
    localparam logic [CNT_W-1:0] NUMER_HIGH_BIT = CNT_W'(223);
    localparam logic [IDX_W-1:0] LAST_WORD      = IDX_W'(NUM_WORDS - 1);

    typedef logic [DIFF_W-1:0] diff_t;
    typedef logic [QUOT_W-1:0] quot_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== design/dtd_divider.sv =====
// restoring long division of the fixed numerator, one quotient bit per cycle
// depends on dtd_pkg
`default_nettype none

module dtd_divider (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire dtd_pkg::diff_t divisor,
    output dtd_pkg::div_status_t status,
    output dtd_pkg::quot_t     quotient
);
    import dtd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    diff_t            rem_reg;
    diff_t            d_reg;
    quot_t            q_reg;

    logic             numer_bit;
    diff_t            shifted;
    logic [DIFF_W:0]  trial;
    logic             ge;
    diff_t            rem_next;

    always_comb
    begin
        numer_bit = (cnt_reg inside {[NUMER_LOW_BIT:NUMER_HIGH_BIT]});
        shifted   = {rem_reg[DIFF_W-2:0], numer_bit};
        // top bit of the rem shift acts as a carry; borrow shows in the msb
        trial     = {rem_reg[DIFF_W-1], shifted} - {1'b0, d_reg};
        ge        = ~trial[DIFF_W];
        rem_next  = ge ? trial[DIFF_W-1:0] : shifted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        d_reg   <= divisor;
                        rem_reg <= '0;
                        cnt_reg <= CNT_W'(QUOT_W - 1);
                        if (divisor == '0)
                        begin
                            q_reg     <= '1;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    rem_reg <= rem_next;
                    q_reg   <= {q_reg[QUOT_W-2:0], ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign quotient    = q_reg;

endmodule

`default_nettype wire

// ===== design/dtd_word_out.sv =====
// splits the 256-bit target into four 64-bit beats, least significant first
// depends on dtd_pkg
`default_nettype none

module dtd_word_out (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire dtd_pkg::quot_t quotient,
    output logic                active,
    output logic [dtd_pkg::IDX_W-1:0] word_index,
    output dtd_pkg::word_t      target_word,
    output logic                last
);
    import dtd_pkg::*;

    logic             active_reg;
    logic [IDX_W-1:0] idx_reg;
    quot_t            buf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
            buf_reg    <= quotient;
        end
        else if (active_reg)
        begin
            buf_reg <= buf_reg >> WORD_W;
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == LAST_WORD)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    assign active      = active_reg;
    assign word_index  = idx_reg;
    assign target_word = buf_reg[WORD_W-1:0];
    assign last        = (idx_reg == LAST_WORD);

endmodule

`default_nettype wire

// ===== design/difficulty_to_target_divider.sv =====
// top level of the difficulty to target divider
// depends on dtd_pkg, dtd_divider and dtd_word_out
//
// usage:
//   a command is taken at a rising edge with start high and busy low; the
//   difficulty port is sampled then. the block returns the 256-bit target
//   floor((0xffff << 208) / difficulty) as four beats on target_word, one
//   per cycle, marked by strobe held high across them, word_index 0
//   (least significant) first; last is high on the word_index 3 beat.
//   a difficulty of zero gives an all-ones target.
// timing:
//   a nonzero difficulty runs through the restoring divider (one
//   quotient bit per cycle through a 64-bit trial subtract), the done
//   state hands the quotient over to the word output, then the beats
//   follow: busy falls after the last beat, so a new command is taken
//   only once all four beats of the last one are out. zero difficulty
//   skips the division and goes straight to the done state.
// reset:
//   rst_n is asynchronous, active low; it drops any command in progress
//   and clears strobe and busy. the receiver cannot stall, so beats are
//   never held back.
`default_nettype none

module difficulty_to_target_divider (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire dtd_pkg::diff_t           difficulty,
    output logic                          strobe,
    output logic [dtd_pkg::IDX_W-1:0]     word_index,
    output dtd_pkg::word_t                target_word,
    output logic                          last
);
    import dtd_pkg::*;

    div_status_t div_status;
    quot_t       quotient;
    logic        out_active;

    dtd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start & ~busy),
        .divisor  (difficulty),
        .status   (div_status),
        .quotient (quotient)
    );

    dtd_word_out u_word_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (div_status.done),
        .quotient    (quotient),
        .active      (out_active),
        .word_index  (word_index),
        .target_word (target_word),
        .last        (last)
    );

    assign busy   = div_status.busy | out_active;
    assign strobe = out_active;

endmodule

`default_nettype wire
